[hw/rtl/dtt_pkg.sv]
// ----------------------------------------------------------------------------
// dtt_pkg: shared constants and helpers for the deadline timer table
// Slot count, field widths, request and result codes, and wait saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package dtt_pkg;

  // Table geometry (PERIOD_BITS may range up to the 24-bit period port)
  localparam int NUM_SLOTS   = 16;
  localparam int PERIOD_BITS = 24;
  localparam int MAX_RESULTS = 16;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDX_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W = 32;
  localparam int WAIT_W = 24;

  // Request opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Clamp a 32-bit wait to the width of the wait field
  function automatic logic [WAIT_W-1:0] sat_wait(input logic [TIME_W-1:0] w);
    if (|w[TIME_W-1:WAIT_W]) begin
      return '1;
    end
    return w[WAIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/deadline_timer_table.sv]
// ----------------------------------------------------------------------------
// deadline_timer_table: millisecond timer table with one-shot and periodic slots
// Add requests claim the lowest free slot; tick requests advance time, fire
// every due slot in slot order and report the wait to the earliest deadline.
// ----------------------------------------------------------------------------
// A request is taken only while the table is idle. Every request makes one
// pass over all NUM_SLOTS slots, one slot per cycle except where a periodic
// reload step is inserted, through a single shared 32-bit adder that also
// serves the time increment, the deadline of a new timer and the reload of a
// periodic timer. An add arms its slot in the ADD step before the pass, and a
// full table goes straight to the pass; a tick first advances the time in the
// INC step and adds a RELOAD step after each periodic timer that fires.
// Results then leave one per cycle while out_stall is low. All results of a
// request carry the armed flag and earliest wait as they stand after the whole
// request. No clearing pass is needed after reset.
`default_nettype none

module deadline_timer_table
  import dtt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_op,
  input  wire logic [23:0]         in_period_ms,
  input  wire logic                in_repeat_req,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_kind,
  output logic [3:0]               out_slot,
  output logic                     out_last,
  output logic                     out_any_armed,
  output logic [WAIT_W-1:0]        out_next_wait
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INC    = 3'd1;
  localparam logic [2:0] ST_ADD    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_RELOAD = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // Control and request registers
  logic [2:0]             state_r, state_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       em_r, em_nxt;
  logic                   any_r, any_nxt;
  logic [WAIT_W-1:0]      best_r, best_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [NUM_SLOTS-1:0]   armed_r, armed_nxt;
  logic                   op_r, op_nxt;
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic                   repeat_r, repeat_nxt;
  logic                   found_r, found_nxt;
  logic [SLOT_W-1:0]      free_slot_r, free_slot_nxt;

  // Slot stores and fired-slot list
  logic                   periodic_r [NUM_SLOTS];
  logic [PERIOD_BITS-1:0] period_mem_r [NUM_SLOTS];
  logic [TIME_W-1:0]      deadline_r [NUM_SLOTS];
  logic [SLOT_W-1:0]      fire_slot_r [MAX_RESULTS];

  // Shared adder
  logic [TIME_W-1:0] op_a, op_b, sum;
  logic              op_sub;

  // Write strobes
  logic add_we, reload_we, fire_we;

  // Scan helpers
  logic              accept;
  logic [SLOT_W-1:0] first_free;
  logic              due, fire, take;
  logic [WAIT_W-1:0] contrib;
  logic [CNT_W-1:0]  em_ext;

  assign accept = in_valid && !in_stall;

  // Pick the lowest free slot
  always_comb begin
    first_free = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!armed_r[i]) begin
        first_free = SLOT_W'(i);
      end
    end
  end

  // Route operands into the shared adder
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state_r)
      ST_INC: begin
        op_a = now_r;
        op_b = TIME_W'(1);
      end
      ST_ADD: begin
        op_a = now_r;
        op_b = TIME_W'(period_r);
      end
      ST_SCAN: begin
        op_a   = deadline_r[idx_r];
        op_b   = now_r;
        op_sub = 1'b1;
      end
      ST_RELOAD: begin
        op_a = now_r;
        op_b = TIME_W'(period_mem_r[idx_r]);
      end
      default: begin
        op_a = '0;
      end
    endcase
    sum = op_a + (op_sub ? ~op_b : op_b) + TIME_W'(op_sub);
  end

  // Deadline reached when deadline - now is zero or beyond half the range
  assign due = (sum == '0) || (sum[TIME_W-1] && (|sum[TIME_W-2:0]));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    em_nxt        = em_r;
    any_nxt       = any_r;
    best_nxt      = best_r;
    now_nxt       = now_r;
    armed_nxt     = armed_r;
    op_nxt        = op_r;
    period_nxt    = period_r;
    repeat_nxt    = repeat_r;
    found_nxt     = found_r;
    free_slot_nxt = free_slot_r;
    add_we        = 1'b0;
    reload_we     = 1'b0;
    fire_we       = 1'b0;
    fire          = 1'b0;
    take          = 1'b0;
    contrib       = '0;
    case (state_r)
      ST_IDLE: begin
        // Latch the request and clear the scan summary
        if (accept) begin
          op_nxt        = in_op;
          period_nxt    = in_period_ms[PERIOD_BITS-1:0];
          repeat_nxt    = in_repeat_req;
          found_nxt     = !(&armed_r);
          free_slot_nxt = first_free;
          idx_nxt       = '0;
          cnt_nxt       = '0;
          em_nxt        = '0;
          any_nxt       = 1'b0;
          best_nxt      = '0;
          if (in_op == OP_TICK) begin
            state_nxt = ST_INC;
          end else if (!(&armed_r)) begin
            state_nxt = ST_ADD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_INC: begin
        // Advance the millisecond counter
        now_nxt   = sum;
        state_nxt = ST_SCAN;
      end
      ST_ADD: begin
        // Arm the claimed slot with deadline now plus period
        add_we                 = 1'b1;
        armed_nxt[free_slot_r] = 1'b1;
        state_nxt              = ST_SCAN;
      end
      ST_SCAN: begin
        // Visit one slot: fire it if due, fold its wait into the summary
        if (armed_r[idx_r]) begin
          fire = (op_r == OP_TICK) && due && (cnt_r != CNT_W'(MAX_RESULTS));
          if (fire) begin
            fire_we = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (periodic_r[idx_r]) begin
              take    = 1'b1;
              contrib = sat_wait(TIME_W'(period_mem_r[idx_r]));
            end else begin
              armed_nxt[idx_r] = 1'b0;
            end
          end else begin
            take    = 1'b1;
            contrib = due ? '0 : sat_wait(sum);
          end
        end
        if (take) begin
          any_nxt = 1'b1;
          if (!any_r || (contrib < best_r)) begin
            best_nxt = contrib;
          end
        end
        if (fire && periodic_r[idx_r]) begin
          state_nxt = ST_RELOAD;
        end else if (idx_r == SLOT_W'(NUM_SLOTS - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_RELOAD: begin
        // Reload the periodic slot, then move on
        reload_we = 1'b1;
        if (idx_r == SLOT_W'(NUM_SLOTS - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SCAN;
          idx_nxt   = idx_r + SLOT_W'(1);
        end
      end
      ST_EMIT: begin
        // Hand out results one per taken transfer
        if (!out_stall) begin
          if (out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            em_nxt = em_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      em_r    <= '0;
      any_r   <= 1'b0;
      best_r  <= '0;
      now_r   <= '0;
      armed_r <= '0;
      op_r    <= OP_TICK;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      em_r    <= em_nxt;
      any_r   <= any_nxt;
      best_r  <= best_nxt;
      now_r   <= now_nxt;
      armed_r <= armed_nxt;
      op_r    <= op_nxt;
      found_r <= found_nxt;
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    period_r    <= period_nxt;
    repeat_r    <= repeat_nxt;
    free_slot_r <= free_slot_nxt;
  end

  // Slot stores
  always_ff @(posedge clk) begin
    if (add_we) begin
      periodic_r[free_slot_r]   <= repeat_r;
      period_mem_r[free_slot_r] <= period_r;
      deadline_r[free_slot_r]   <= sum;
    end else if (reload_we) begin
      deadline_r[idx_r] <= sum;
    end
  end

  // Record fired slots in firing order
  always_ff @(posedge clk) begin
    if (fire_we) begin
      fire_slot_r[cnt_r[IDX_W-1:0]] <= idx_r;
    end
  end

  // Result fields, all taken from registers
  assign em_ext    = CNT_W'(em_r);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    if (op_r == OP_ADD) begin
      out_kind = found_r ? KIND_ADDED : KIND_FULL;
      out_slot = found_r ? 4'(free_slot_r) : 4'd0;
      out_last = 1'b1;
    end else if (cnt_r == '0) begin
      out_kind = KIND_NONE;
      out_slot = 4'd0;
      out_last = 1'b1;
    end else begin
      out_kind = KIND_FIRED;
      out_slot = 4'(fire_slot_r[em_r]);
      out_last = (em_ext == cnt_r - CNT_W'(1));
    end
  end

  assign out_any_armed = any_r;
  assign out_next_wait = best_r;

  // A wait is only reported while some timer stays armed
  a_wait_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_armed |-> out_next_wait == '0)
    else $error("next_wait nonzero with no armed timer");

  // The firing count never passes the per-tick limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("firing count beyond limit");

  // A reload only follows a slot visit
  a_reload_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RELOAD |-> $past(state_r) == ST_SCAN)
    else $error("reload without a preceding slot visit");

  // An add result always names an armed slot
  a_added_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ADDED |-> armed_r[free_slot_r])
    else $error("added slot is not armed");

endmodule

`default_nettype wire

[bench/timer_table_checker.sv]
// ----------------------------------------------------------------------------
// timer_table_checker: result predictor and scoreboard for the timer table
// Watches both channels, keeps a shadow copy of the timer slots, works out
// the results of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module timer_table_checker
  import dtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_op,
  input  logic [23:0]       in_period_ms,
  input  logic              in_repeat_req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_kind,
  input  logic [3:0]        out_slot,
  input  logic              out_last,
  input  logic              out_any_armed,
  input  logic [WAIT_W-1:0] out_next_wait,
  output int                fail_count,
  output int                outstanding,
  output int                result_count,
  output int                fire_count,
  output int                full_count,
  output int                widest_burst
);

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        slot;
    logic              last;
    logic              any_armed;
    logic [WAIT_W-1:0] next_wait;
  } timer_result_t;

  // Shadow of the timer table
  logic [TIME_W-1:0] now_ms;
  logic              armed    [NUM_SLOTS];
  logic              periodic [NUM_SLOTS];
  logic [TIME_W-1:0] reload   [NUM_SLOTS];
  logic [TIME_W-1:0] deadline [NUM_SLOTS];

  timer_result_t pending_results[$];

  // Deadline reached, compared modulo 2^32
  function automatic logic is_reached(input logic [TIME_W-1:0] dl);
    logic [TIME_W-1:0] diff;
    diff = now_ms - dl;
    return !diff[TIME_W-1];
  endfunction

  // Apply one request to the shadow table and queue the results it causes
  task automatic step_timer_table(input logic op, input logic [23:0] per,
                                  input logic rep);
    timer_result_t     batch[$];
    timer_result_t     r;
    int                found;
    logic              any;
    logic [TIME_W-1:0] best;
    logic [TIME_W-1:0] w;
    logic [TIME_W-1:0] kept;
    kept = TIME_W'(per) & ((TIME_W'(1) << PERIOD_BITS) - 1);
    r = '0;
    if (op == OP_ADD) begin
      found = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!armed[i] && found < 0) found = i;
      end
      if (found >= 0) begin
        armed[found]    = 1'b1;
        periodic[found] = rep;
        reload[found]   = kept;
        deadline[found] = now_ms + kept;
        r.kind = KIND_ADDED;
        r.slot = 4'(found);
      end else begin
        r.kind = KIND_FULL;
        full_count++;
      end
      batch.push_back(r);
    end else begin
      now_ms = now_ms + 1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (batch.size() < MAX_RESULTS && armed[i] && is_reached(deadline[i])) begin
          if (periodic[i]) deadline[i] = now_ms + reload[i];
          else armed[i] = 1'b0;
          r.kind = KIND_FIRED;
          r.slot = 4'(i);
          batch.push_back(r);
          fire_count++;
        end
      end
      if (batch.size() == 0) begin
        r.kind = KIND_NONE;
        batch.push_back(r);
      end
      if (batch.size() > widest_burst) widest_burst = batch.size();
    end
    // Summarise the table as it stands after the whole request
    any  = 1'b0;
    best = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (armed[i]) begin
        w = is_reached(deadline[i]) ? '0 : deadline[i] - now_ms;
        if (!any || w < best) best = w;
        any = 1'b1;
      end
    end
    foreach (batch[k]) begin
      r           = batch[k];
      r.last      = (k == batch.size() - 1);
      r.any_armed = any;
      r.next_wait = !any ? '0 : (|best[TIME_W-1:WAIT_W]) ? '1 : best[WAIT_W-1:0];
      pending_results.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Predict on accepted requests, check accepted results in order
  always @(posedge clk) begin : scoreboard
    timer_result_t want;
    if (!rst_n) begin
      now_ms = '0;
      for (int i = 0; i < NUM_SLOTS; i++) armed[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) step_timer_table(in_op, in_period_ms, in_repeat_req);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d slot %0d", out_kind, out_slot);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", 32'(want.kind), 32'(out_kind));
          compare_field("slot", 32'(want.slot), 32'(out_slot));
          compare_field("last", 32'(want.last), 32'(out_last));
          compare_field("any_armed", 32'(want.any_armed), 32'(out_any_armed));
          compare_field("next_wait", 32'(want.next_wait), 32'(out_next_wait));
          result_count++;
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the deadline timer table
// Drives a directed opening (empty ticks, zero periods, a full table and a
// wide firing burst) followed by random add and tick requests, with random
// idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import dtt_pkg::*;

  localparam int ITEMS        = 430;
  localparam int QUIET_TAIL   = 60;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int LASTING_CAP  = 7;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_TIME   = 4000000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [23:0]       in_period_ms;
  logic              in_repeat_req;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_kind;
  logic [3:0]        out_slot;
  logic              out_last;
  logic              out_any_armed;
  logic [WAIT_W-1:0] out_next_wait;

  int fail_count;
  int outstanding;
  int result_count;
  int fire_count;
  int full_count;
  int widest_burst;

  int sent;
  int add_count;
  int tick_count;
  int lasting;
  bit quiet;
  bit hold_req;
  bit hold_done;

  deadline_timer_table u_dut (.*);

  timer_table_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #LIMIT_TIME;
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one request, hold it until taken, then maybe idle for a burst
  task automatic send_request(input logic op, input logic [23:0] per, input logic rep);
    in_valid      <= 1'b1;
    in_op         <= op;
    in_period_ms  <= per;
    in_repeat_req <= rep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (op == OP_ADD) add_count++;
    else tick_count++;
    if (sent == HOLD_AT) hold_req = 1'b1;
    if (sent >= ITEMS - QUIET_TAIL) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stall results in random bursts, once for a long stretch
  initial begin : result_stall
    int len;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        len = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        len = $urandom_range(1, 6);
        out_stall <= 1'b1;
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        out_stall <= 1'b0;
      end
      repeat (len) @(posedge clk);
    end
  end

  initial begin : stimulus
    int          pick;
    int          sub;
    int          group;
    logic [23:0] per;
    logic        rep;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_TICK;
    in_period_ms  <= '0;
    in_repeat_req <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, zero period, longest period, full table, burst
    send_request(OP_TICK, 24'($urandom), 1'($urandom));
    send_request(OP_ADD, 24'd0, 1'b0);
    send_request(OP_TICK, 24'($urandom), 1'($urandom));
    send_request(OP_ADD, 24'hFF_FFFF, 1'b0);
    send_request(OP_ADD, 24'd3, 1'b1);
    send_request(OP_ADD, 24'd0, 1'b1);
    repeat (13) send_request(OP_ADD, 24'd2, 1'b0);
    send_request(OP_ADD, 24'd5, 1'b1);
    repeat (4) send_request(OP_TICK, 24'($urandom), 1'($urandom));
    lasting = 3;

    // Random: mostly ticks, adds of mixed lifetimes, groups sharing a deadline
    while (sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        per   = 24'($urandom_range(0, 12));
        group = $urandom_range(3, 8);
        repeat (group) send_request(OP_ADD, per, 1'b0);
      end else if (pick < 40) begin
        sub = $urandom_range(0, 99);
        if (lasting < LASTING_CAP && sub < 5) begin
          per = 24'($urandom);
          rep = 1'($urandom);
          lasting++;
        end else if (lasting < LASTING_CAP && sub < 15) begin
          per = 24'($urandom_range(0, 40));
          rep = 1'b1;
          lasting++;
        end else if (sub < 30) begin
          per = 24'($urandom_range(21, 300));
          rep = 1'b0;
        end else begin
          per = 24'($urandom_range(0, 20));
          rep = 1'b0;
        end
        send_request(OP_ADD, per, rep);
      end else begin
        send_request(OP_TICK, 24'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain the remaining results, then allow for stragglers
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d adds, %0d ticks) and %0d results.",
             sent, add_count, tick_count, result_count);
    $display("Timer firings %0d, table-full replies %0d, widest tick burst %0d.",
             fire_count, full_count, widest_burst);
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[deadline_timer_table.f]
hw/rtl/dtt_pkg.sv
hw/rtl/deadline_timer_table.sv
bench/timer_table_checker.sv
bench/testbench.sv
